// ----- src/msc_pkg.sv -----
// Shared types and constants of the minimum square sum count unit.
`timescale 1ns / 1ps

package msc_pkg;

   // Fixed widths of the item fields.
   localparam int QUERY_W = 14;
   localparam int COUNT_W = 3;

   // Starting value of the running minimum; above every real count.
   localparam logic [COUNT_W-1:0] COUNT_INIT = 3'd7;

   // Sequencer states of the table fill engine.
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DRAIN  = 5'b00100,
      ST_READ   = 5'b01000,
      ST_ANSWER = 5'b10000
   } core_state_type;

   // Request from the front end to the fill engine.
   typedef struct packed {
      logic               valid;
      logic [QUERY_W-1:0] target;
   } core_go_type;

   // Answer from the fill engine to the front end.
   typedef struct packed {
      logic               valid;
      logic [COUNT_W-1:0] count;
   } core_done_type;

endpackage

// ----- src/msc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module msc_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/msc_core.sv -----
// Table fill engine: extends the count table one entry at a time and reads answers.
`timescale 1ns / 1ps

module msc_core #(
   parameter int MAX_VALUE = 16383
) (
   input  logic                  clock,
   input  logic                  reset,
   input  msc_pkg::core_go_type   go,
   output msc_pkg::core_done_type done
);

   import msc_pkg::*;

   localparam int AW = $clog2(MAX_VALUE + 1);
   localparam int SW = AW + 1;

   core_state_type state_ff, state_in;
   logic [AW-1:0]      filled_ff, filled_in;
   logic [AW-1:0]      target_ff, target_in;
   logic [AW-1:0]      m_ff, m_in;
   logic [AW-1:0]      i_ff, i_in;
   logic [SW-1:0]      s_ff, s_in;
   logic [COUNT_W-1:0] best_ff, best_in;
   logic               pend_ff, pend_in;
   logic               rd_zero_ff, rd_zero_in;

   logic [AW-1:0]      rd_addr;
   logic [COUNT_W-1:0] ram_rd_data;
   logic [COUNT_W-1:0] rd_val;
   logic [COUNT_W-1:0] cand;
   logic [COUNT_W-1:0] best_fold;
   logic               scan_more;
   logic               wr_en;

   msc_ram #(
      .WIDTH(COUNT_W),
      .DEPTH(MAX_VALUE + 1)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(m_ff),
      .wr_data(best_fold),
      .rd_addr(rd_addr),
      .rd_data(ram_rd_data)
   );

   // Entry zero is never written; it always reads as the empty sum.
   assign rd_val    = rd_zero_ff ? '0 : ram_rd_data;
   assign cand      = rd_val + COUNT_W'(1);
   assign best_fold = (pend_ff && (cand < best_ff)) ? cand : best_ff;
   assign scan_more = ({1'b0, m_ff} >= s_ff);
   assign wr_en     = (state_ff == ST_DRAIN);
   assign rd_addr   = (state_ff == ST_SCAN) ? AW'({1'b0, m_ff} - s_ff) : target_ff;
   assign rd_zero_in = (rd_addr == '0);

   assign done.valid = (state_ff == ST_ANSWER);
   assign done.count = rd_val;

   always_comb begin
      state_in  = state_ff;
      filled_in = filled_ff;
      target_in = target_ff;
      m_in      = m_ff;
      i_in      = i_ff;
      s_in      = s_ff;
      best_in   = best_ff;
      pend_in   = pend_ff;
      case (state_ff)
         ST_IDLE: begin
            if (go.valid) begin
               target_in = AW'(go.target);
               if (AW'(go.target) > filled_ff) begin
                  m_in     = filled_ff + AW'(1);
                  i_in     = AW'(1);
                  s_in     = SW'(1);
                  best_in  = COUNT_INIT;
                  pend_in  = 1'b0;
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_SCAN: begin
            best_in = best_fold;
            if (scan_more) begin
               pend_in = 1'b1;
               i_in    = i_ff + AW'(1);
               s_in    = s_ff + {i_ff, 1'b1};
            end else begin
               pend_in  = 1'b0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            filled_in = m_ff;
            if (m_ff == target_ff) begin
               state_in = ST_READ;
            end else begin
               m_in     = m_ff + AW'(1);
               i_in     = AW'(1);
               s_in     = SW'(1);
               best_in  = COUNT_INIT;
               pend_in  = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_READ: begin
            state_in = ST_ANSWER;
         end
         ST_ANSWER: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         filled_ff <= '0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         filled_ff <= filled_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff  <= target_in;
      m_ff       <= m_in;
      i_ff       <= i_in;
      s_ff       <= s_in;
      best_ff    <= best_in;
      rd_zero_ff <= rd_zero_in;
   end

endmodule

// ----- src/min_square_sum_count_unit.sv -----
// Top level of the minimum square sum count unit: command handshake and answer strobe.
`timescale 1ns / 1ps

// This unit answers, for a query value n, the least number of perfect squares that
// sum to n (always 0 to 4). An item is taken at a rising clock edge where start is
// high and busy is low; for a query that goes to the table, busy then stays high
// until the answer has been produced. The answer appears on rsp_square_count for
// exactly one cycle with rsp_valid high, and the receiver cannot stall it. A query of
// zero, or one above MAX_VALUE, is answered with zero in the cycle after it is taken.
// Results live in a table RAM that is filled on demand in increasing order, so a
// query at or below the highest value seen so far is answered through a table read
// in the READ state, the ANSWER state and the answer register, and the next item can
// be taken at the edge that ends its answer strobe. A larger query first fills each
// missing entry m in turn: in the SCAN state the single read port of the table is
// visited once per square not above m, a last SCAN step folds the last read into the
// minimum, and the DRAIN state writes the entry. The table needs no clearing pass
// after reset; each entry but entry zero (read as zero) is written before it is read.

module min_square_sum_count_unit #(
   parameter int MAX_VALUE = 16383
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [msc_pkg::QUERY_W-1:0]   req_query_value,
   output logic                          rsp_valid,
   output logic [msc_pkg::COUNT_W-1:0]   rsp_square_count
);

   import msc_pkg::*;

   logic               busy_ff, busy_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic          accept;
   logic          out_of_range;
   logic          zero_query;
   core_go_type   go;
   core_done_type done;

   msc_core #(
      .MAX_VALUE(MAX_VALUE)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .go   (go),
      .done (done)
   );

   // A query that does not fit the table is answered with zero and leaves it alone.
   assign accept       = start && !busy_ff;
   assign out_of_range = (32'(req_query_value) > 32'(MAX_VALUE));
   assign zero_query   = (req_query_value == '0);

   assign go.valid  = accept && !out_of_range && !zero_query;
   assign go.target = req_query_value;

   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = 1'b0;
      rsp_count_in = '0;
      if (done.valid) begin
         // The engine's answer ends the item.
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_count_in = done.count;
      end else if (accept) begin
         if (out_of_range || zero_query) begin
            rsp_valid_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
   end

   assign busy             = busy_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_square_count = rsp_count_ff;

endmodule

// ----- src/msc_checker.sv -----
// Port-level assertions for the minimum square sum count unit, with their bind.
`timescale 1ns / 1ps

module msc_checker #(
   parameter int MAX_VALUE = 16383
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [msc_pkg::QUERY_W-1:0]   req_query_value,
   input logic                          rsp_valid,
   input logic [msc_pkg::COUNT_W-1:0]   rsp_square_count
);

   import msc_pkg::*;

   // Every answer is bounded by the four-square theorem.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_square_count <= COUNT_W'(4)))
      else $error("square count above four");

   // A zero query is answered with zero in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_query_value == '0)) |=> (rsp_valid && (rsp_square_count == '0)))
      else $error("zero query not answered with zero");

   // A nonzero query within range raises busy, with no answer strobe yet.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_query_value != '0) &&
       (32'(req_query_value) <= 32'(MAX_VALUE))) |=> (busy && !rsp_valid))
      else $error("table query did not hold busy");

   // Busy drops only together with the answer strobe.
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_valid)
      else $error("busy dropped without an answer");

   // An answer is never shown while an item is still at work.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("answer strobe while busy");

endmodule

bind min_square_sum_count_unit msc_checker #(.MAX_VALUE(MAX_VALUE)) u_checker (.*);
